// ===== rtl/srt_pkg.sv =====
// shared types, codes and defaults for the segment reservation table
package srt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 128;
	localparam int unsigned MAX_LIST_DEF      = 32;

	localparam logic [1:0] STAT_GRANTED  = 2'd0;
	localparam logic [1:0] STAT_CONFLICT = 2'd1;
	localparam logic [1:0] STAT_QUERY    = 2'd2;
	localparam logic [1:0] STAT_OVERFLOW = 2'd3;

	localparam logic [7:0] OWNER_FREE = 8'h00;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_CHECK,
		FSM_FREE,
		FSM_GRANT,
		FSM_RESP
	} fsm_t;

endpackage

// ===== rtl/segment_reservation_table.sv =====
// segment reservation table: owner memory, request list buffer and commit sequencer
//
//   channel | direction | handshake            | payload
//   s_*     | in        | s_tvalid / s_tready  | s_tdata, s_tuser (func), s_tlast (last_entry)
//   m_*     | out       | m_tvalid / m_tready  | m_tdata, m_tuser (status)
//
// a list entry fills the list buffer; a query is a table read, then the answer register
// a commit runs a check over the list, a release over every table entry, a grant over the
// list and an answer, set by the single read port of the owner memory and list buffer
// reset clears the per-segment valid bits at once, so no clearing pass is needed
// a waiting answer does not stop list entries; a new answer waits for the output register
module segment_reservation_table
	import srt_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int unsigned MAX_LIST      = MAX_LIST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // requester [7:0], node [15:8]
	input  logic        s_tuser,  // func [0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // owner [7:0], failed_node [15:8]
	output logic [1:0]  m_tuser   // status [1:0]
);

	localparam int unsigned IW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = $clog2(MAX_LIST + 1);
	localparam int unsigned BW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
	localparam logic [IW-1:0] LAST_SEG = IW'(TABLE_ENTRIES - 1);
	localparam logic [CW-1:0] LIST_MAX = CW'(MAX_LIST);

	logic [IW-1:0] seg_lut [128];

	for (genvar g = 0; g < 128; g++) begin : g_seg
		localparam int unsigned R = g % TABLE_ENTRIES;
		assign seg_lut[g] = IW'(R);
	end

	logic [7:0]          owner_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] tbl_vld_q;
	logic [7:0]          tbl_rdata_q;
	logic                tbl_rvld_q;
	logic [7:0]          buf_mem [MAX_LIST];
	logic [7:0]          buf_rdata_q;

	fsm_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic [7:0]    own_q;
	logic          ovf_q;
	logic [CW-1:0] iss_q;
	logic [IW-1:0] fr_q;
	logic          fr_done_q;
	logic          v_s1, v_s2;
	logic [7:0]    node_s2;
	logic [IW-1:0] fr_addr_s1;
	logic [1:0]    res_status_q;
	logic [7:0]    res_fail_q;
	logic          out_valid_q;
	logic [15:0]   out_data_q;
	logic [1:0]    out_user_q;

	logic          in_fire, list_fire, query_fire, buf_wr_en;
	logic          tbl_rd_en, tbl_wr_en, tbl_clr_en, buf_rd_en;
	logic [IW-1:0] tbl_rd_addr, tbl_wr_addr;
	logic          issue_c, conflict_c, out_free, resp_fire, list_ovf;
	logic          check_done, free_done, grant_done;
	logic [7:0]    held;

	assign held      = tbl_rvld_q ? tbl_rdata_q : OWNER_FREE;
	assign out_free  = !out_valid_q || m_tready;
	assign in_fire   = s_tvalid && s_tready;
	assign list_fire = in_fire && !s_tuser;
	assign query_fire = in_fire && s_tuser;
	assign buf_wr_en = list_fire && (cnt_q < LIST_MAX);
	assign list_ovf  = ovf_q || (cnt_q == LIST_MAX);

	assign check_done = (iss_q == cnt_q) && !v_s1 && !v_s2;
	assign free_done  = fr_done_q && !v_s1;
	assign grant_done = (iss_q == cnt_q) && !v_s1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (query_fire) begin
					state_d = FSM_RESP;
				end else if (list_fire && s_tlast) begin
					state_d = list_ovf ? FSM_RESP : FSM_CHECK;
				end
			end
			FSM_CHECK: begin
				if (conflict_c) begin
					state_d = FSM_RESP;
				end else if (check_done) begin
					state_d = FSM_FREE;
				end
			end
			FSM_FREE: begin
				if (free_done) state_d = FSM_GRANT;
			end
			FSM_GRANT: begin
				if (grant_done) state_d = FSM_RESP;
			end
			FSM_RESP: begin
				if (out_free) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		tbl_rd_en   = 1'b0;
		tbl_rd_addr = seg_lut[s_tdata[15:9]];
		tbl_wr_en   = 1'b0;
		tbl_clr_en  = 1'b0;
		tbl_wr_addr = seg_lut[buf_rdata_q[7:1]];
		buf_rd_en   = 1'b0;
		issue_c     = 1'b0;
		conflict_c  = 1'b0;
		resp_fire   = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				s_tready  = 1'b1;
				tbl_rd_en = s_tvalid && s_tuser;
			end
			FSM_CHECK: begin
				conflict_c  = v_s2 && (held != own_q) && (held != OWNER_FREE);
				issue_c     = (iss_q < cnt_q) && !conflict_c;
				buf_rd_en   = issue_c;
				tbl_rd_en   = v_s1;
				tbl_rd_addr = seg_lut[buf_rdata_q[7:1]];
			end
			FSM_FREE: begin
				issue_c     = !fr_done_q;
				tbl_rd_en   = issue_c;
				tbl_rd_addr = fr_q;
				tbl_clr_en  = v_s1 && (held == own_q);
				tbl_wr_addr = fr_addr_s1;
			end
			FSM_GRANT: begin
				issue_c   = iss_q < cnt_q;
				buf_rd_en = issue_c;
				tbl_wr_en = v_s1;
			end
			FSM_RESP: begin
				resp_fire = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_wr_en) owner_mem[tbl_wr_addr] <= own_q;
		if (tbl_rd_en) begin
			tbl_rdata_q <= owner_mem[tbl_rd_addr];
			tbl_rvld_q  <= tbl_vld_q[tbl_rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (tbl_wr_en) begin
			tbl_vld_q[tbl_wr_addr] <= 1'b1;
		end else if (tbl_clr_en) begin
			tbl_vld_q[tbl_wr_addr] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_wr_en) buf_mem[cnt_q[BW-1:0]] <= s_tdata[15:8];
		if (buf_rd_en) buf_rdata_q <= buf_mem[iss_q[BW-1:0]];
	end

	always_ff @(posedge clk) begin
		node_s2    <= buf_rdata_q;
		fr_addr_s1 <= fr_q;
		if (query_fire) res_fail_q <= 8'h00;
		if (conflict_c) res_fail_q <= node_s2;
		if (resp_fire) begin
			out_user_q        <= res_status_q;
			out_data_q[7:0]   <= (res_status_q == STAT_QUERY) ? held : OWNER_FREE;
			out_data_q[15:8]  <= (res_status_q == STAT_CONFLICT) ? res_fail_q : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_IDLE;
			cnt_q        <= '0;
			own_q        <= '0;
			ovf_q        <= 1'b0;
			iss_q        <= '0;
			fr_q         <= '0;
			fr_done_q    <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			res_status_q <= STAT_GRANTED;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue_c;
			v_s2    <= (state_q == FSM_CHECK) && v_s1 && !conflict_c;

			if (list_fire) begin
				if (cnt_q == '0 && !ovf_q) own_q <= s_tdata[7:0];
				if (buf_wr_en) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (s_tlast) res_status_q <= list_ovf ? STAT_OVERFLOW : STAT_GRANTED;
			end
			if (query_fire) res_status_q <= STAT_QUERY;
			if (conflict_c) res_status_q <= STAT_CONFLICT;

			if ((state_q == FSM_CHECK || state_q == FSM_GRANT) && issue_c) begin
				iss_q <= iss_q + CW'(1);
			end else if (state_q != FSM_CHECK && state_q != FSM_GRANT) begin
				iss_q <= '0;
			end

			if (state_q == FSM_FREE) begin
				if (issue_c) begin
					fr_q      <= fr_q + IW'(1);
					fr_done_q <= (fr_q == LAST_SEG);
				end
			end else begin
				fr_q      <= '0;
				fr_done_q <= 1'b0;
			end

			if (resp_fire) begin
				out_valid_q <= 1'b1;
				if (res_status_q != STAT_QUERY) begin
					cnt_q <= '0;
					own_q <= '0;
					ovf_q <= 1'b0;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef ASSERT_OFF
	a_no_write_and_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_wr_en && tbl_clr_en))
		else $error("table write and release in the same cycle");

	a_check_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("check stage two without stage one");

	a_grant_clean_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_GRANT) |-> (!ovf_q && cnt_q != '0))
		else $error("grant with an empty or overflowed list");

	a_last_starts_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(list_fire && s_tlast) |=> (state_q == FSM_CHECK || state_q == FSM_RESP))
		else $error("last list entry did not start a commit");

	a_answer_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == FSM_RESP))
		else $error("answer raised outside the answer state");
`endif

endmodule
